/* hw/rtl/pia_pkg.sv */
// Shared types and constants for the positional insert/delete array.
// Holds field widths, request and status codes, and the command and status
// structs that join the controller to the datapath. Depends on nothing.
package pia_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Request kinds carried on the input tuser.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  // Result status carried on the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // How the datapath updates its read index.
  typedef enum logic [2:0] {
    IDX_HOLD      = 3'd0,
    IDX_INS_START = 3'd1,
    IDX_DEL_START = 3'd2,
    IDX_ZERO      = 3'd3,
    IDX_DEC       = 3'd4,
    IDX_INC       = 3'd5
  } idx_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_ld;       // latch value and position of the accepted item
    idx_sel_e idx_sel;     // read index update
    logic     mem_rd;      // read the memory at the read index
    logic     shift_wr;    // write back the word read in the previous cycle
    logic     ins_dir;     // shift direction: 1 moves words up (insert)
    logic     val_wr;      // write the latched value at the latched position
    logic     cnt_inc;     // one more stored entry
    logic     cnt_dec;     // one stored entry fewer
    logic     out_ld;      // load the output register
    logic     out_dump;    // output carries a stored entry
    status_e  out_status;  // status of a single result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // count equals the depth
    logic empty;      // count is zero
    logic ins_bad;    // incoming position above count
    logic ins_end;    // incoming position equals count
    logic del_bad;    // incoming position at or above count
    logic del_end;    // incoming position is the last entry
    logic rd_last;    // read index reached the end of the shift range
    logic dump_last;  // the word in the read register is the last entry
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

/* hw/rtl/pia_ctrl.sv */
// Controller state machine of the positional insert/delete array.
// Decodes each request and sequences shifts, writes, dumps and responses.
// Depends on pia_pkg for the command and status structs.
module pia_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [pia_pkg::REQ_W-1:0]         req_type_i,
  input  pia_pkg::stat_t                    stat_i,
  output pia_pkg::cmd_t                     cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_FLUSH = 7'b0000100,
    S_INSWR = 7'b0001000,
    S_RESP  = 7'b0010000,
    S_DRD   = 7'b0100000,
    S_DOUT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic              ins_q, ins_d;
  pia_pkg::status_e  status_q, status_d;
  logic              in_acc;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i & s_tready_o;

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    ins_d    = ins_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.idx_sel    = pia_pkg::IDX_HOLD;
    cmd_o.out_status = status_q;
    cmd_o.ins_dir    = ins_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.in_ld = 1'b1;
          status_d    = pia_pkg::ST_OK;
          state_d     = S_RESP;
          case (req_type_i)
            pia_pkg::REQ_INSERT: begin
              ins_d = 1'b1;
              if (stat_i.full) begin
                status_d = pia_pkg::ST_FULL;
              end else if (stat_i.ins_bad) begin
                status_d = pia_pkg::ST_BADPOS;
              end else if (stat_i.ins_end) begin
                state_d = S_INSWR;
              end else begin
                cmd_o.idx_sel = pia_pkg::IDX_INS_START;
                state_d       = S_SHIFT;
              end
            end
            pia_pkg::REQ_DELETE: begin
              ins_d = 1'b0;
              if (stat_i.empty) begin
                status_d = pia_pkg::ST_EMPTY;
              end else if (stat_i.del_bad) begin
                status_d = pia_pkg::ST_BADPOS;
              end else if (stat_i.del_end) begin
                state_d = S_FLUSH;
              end else begin
                cmd_o.idx_sel = pia_pkg::IDX_DEL_START;
                state_d       = S_SHIFT;
              end
            end
            pia_pkg::REQ_DUMP: begin
              ins_d = 1'b0;
              if (stat_i.empty) begin
                status_d = pia_pkg::ST_EMPTY;
              end else begin
                cmd_o.idx_sel = pia_pkg::IDX_ZERO;
                state_d       = S_DRD;
              end
            end
            default: begin
              status_d = pia_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      // Read one word and write back the previous one every cycle.
      S_SHIFT: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.shift_wr = 1'b1;
        cmd_o.idx_sel  = ins_q ? pia_pkg::IDX_DEC : pia_pkg::IDX_INC;
        if (stat_i.rd_last) begin
          state_d = S_FLUSH;
        end
      end
      // Write back the last word read, if any; a delete drops one entry here.
      S_FLUSH: begin
        cmd_o.shift_wr = 1'b1;
        cmd_o.cnt_dec  = ~ins_q;
        state_d        = ins_q ? S_INSWR : S_RESP;
      end
      S_INSWR: begin
        cmd_o.val_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_DOUT;
      end
      // Hand one stored entry to the output register.
      S_DOUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_dump = 1'b1;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_sel = pia_pkg::IDX_INC;
            state_d       = S_DRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ins_q    <= 1'b0;
      status_q <= pia_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      ins_q    <= ins_d;
      status_q <= status_d;
    end
  end

endmodule

/* hw/rtl/pia_dp.sv */
// Datapath of the positional insert/delete array: entry memory, fill count,
// read and shift registers, and the output register.
// Depends on pia_pkg; driven by commands from pia_ctrl.
module pia_dp #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pia_pkg::cmd_t                       cmd_i,
  input  logic signed [pia_pkg::VALUE_W-1:0]  in_value_i,
  input  logic [pia_pkg::POS_W-1:0]           in_position_i,
  input  logic                                out_tready_i,
  output pia_pkg::stat_t                      stat_o,
  output logic                                out_tvalid_o,
  output logic [pia_pkg::STATUS_W-1:0]        out_status_o,
  output logic signed [pia_pkg::VALUE_W-1:0]  out_value_o,
  output logic                                out_last_o,
  output logic [pia_pkg::FILL_W-1:0]          out_fill_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > pia_pkg::POS_W) ? CW : pia_pkg::POS_W;

  logic signed [WORD_WIDTH-1:0]       mem [DEPTH];
  logic [CW-1:0]                      count_q, count_d;
  logic [AW-1:0]                      rd_idx_q, rd_idx_d;
  logic [AW-1:0]                      src_q;
  logic                               rd_vld_q;
  logic signed [WORD_WIDTH-1:0]       rdata_q;
  logic signed [pia_pkg::VALUE_W-1:0] value_q;
  logic [pia_pkg::POS_W-1:0]          pos_q;
  logic                               out_vld_q;
  logic [pia_pkg::STATUS_W-1:0]       out_status_q;
  logic signed [pia_pkg::VALUE_W-1:0] out_value_q;
  logic                               out_last_q;
  logic [pia_pkg::FILL_W-1:0]         out_fill_q;
  logic [XW-1:0]                      pos_x, cnt_x;
  logic [CW-1:0]                      cnt_m1;
  logic                               wr_en;
  logic [AW-1:0]                      wr_addr;
  logic signed [WORD_WIDTH-1:0]       wr_data;

  // Checks of the incoming position against the fill count.
  assign pos_x  = XW'(in_position_i);
  assign cnt_x  = XW'(count_q);
  assign cnt_m1 = count_q - CW'(1);

  always_comb begin
    stat_o.full      = (count_q == CW'(DEPTH));
    stat_o.empty     = (count_q == '0);
    stat_o.ins_bad   = (pos_x > cnt_x);
    stat_o.ins_end   = (pos_x == cnt_x);
    stat_o.del_bad   = (pos_x >= cnt_x);
    stat_o.del_end   = ((pos_x + XW'(1)) == cnt_x);
    stat_o.rd_last   = cmd_i.ins_dir ? (XW'(rd_idx_q) == XW'(pos_q))
                                     : (CW'(rd_idx_q) == cnt_m1);
    stat_o.dump_last = (CW'(src_q) == cnt_m1);
    stat_o.out_free  = ~out_vld_q | out_tready_i;
  end

  // Read index.
  always_comb begin
    case (cmd_i.idx_sel)
      pia_pkg::IDX_INS_START: rd_idx_d = AW'(cnt_m1);
      pia_pkg::IDX_DEL_START: rd_idx_d = AW'(pos_x + XW'(1));
      pia_pkg::IDX_ZERO:      rd_idx_d = '0;
      pia_pkg::IDX_DEC:       rd_idx_d = rd_idx_q - AW'(1);
      pia_pkg::IDX_INC:       rd_idx_d = rd_idx_q + AW'(1);
      default:                rd_idx_d = rd_idx_q;
    endcase
  end

  // Fill count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = cnt_m1;
    end
  end

  // Memory write: either a shifted word or the inserted value.
  assign wr_en   = cmd_i.val_wr | (cmd_i.shift_wr & rd_vld_q);
  assign wr_data = cmd_i.val_wr ? WORD_WIDTH'(value_q) : rdata_q;
  always_comb begin
    if (cmd_i.val_wr) begin
      wr_addr = AW'(pos_q);
    end else if (cmd_i.ins_dir) begin
      wr_addr = src_q + AW'(1);
    end else begin
      wr_addr = src_q - AW'(1);
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[rd_idx_q];
      src_q   <= rd_idx_q;
    end
  end

  // Latched request fields and read index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ld) begin
      value_q <= in_value_i;
      pos_q   <= in_position_i;
    end
    rd_idx_q <= rd_idx_d;
  end

  // Control state of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_vld_q <= cmd_i.mem_rd;
      if (cmd_i.out_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_status_q <= cmd_i.out_dump ? pia_pkg::ST_OK : cmd_i.out_status;
      out_value_q  <= cmd_i.out_dump ? pia_pkg::VALUE_W'(rdata_q) : '0;
      out_last_q   <= cmd_i.out_dump ? stat_o.dump_last : 1'b1;
      out_fill_q   <= pia_pkg::FILL_W'(count_q);
    end
  end

  assign out_tvalid_o = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;
  assign out_fill_o   = out_fill_q;

`ifndef NO_ASSERTIONS
  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("fill count above depth");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_rd |-> (CW'(rd_idx_q) < count_q)) else $error("read of unfilled entry");

  a_insert_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.val_wr |-> (XW'(pos_q) <= XW'(count_q))) else $error("insert beyond fill");

  a_out_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> (!out_vld_q || out_tready_i)) else $error("output item overwritten");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow count");
`endif

endmodule

/* hw/rtl/positional_insert_delete_array.sv */
// Positional insert/delete array: keeps up to DEPTH signed words in order.
// Insert moves the words from the position upward one slot, one word per
// cycle through the entry memory's single read and write port, then writes
// the value; delete moves the words above the position down one slot. A
// dump reads every stored entry in turn, one memory read and one output
// load each. Rejected or unknown requests give a single result with an
// error status. A stalled output holds the block while it waits. One
// request is worked on at a time; a new item is taken once the previous
// one has put its last result into the output register. Status travels on
// the output tuser; the fill count after the request comes with every
// result. There is no clearing pass.
module positional_insert_delete_array #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [31:0] value, [38:32] position, [39] zero
  input  logic [pia_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // [1:0] req_type
  input  logic [pia_pkg::REQ_W-1:0]           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] entry_value, [38:32] fill_count, [39] zero
  output logic [pia_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  // [1:0] status
  output logic [pia_pkg::STATUS_W-1:0]        m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);

  pia_pkg::cmd_t                      cmd;
  pia_pkg::stat_t                     stat;
  logic signed [pia_pkg::VALUE_W-1:0] in_value;
  logic [pia_pkg::POS_W-1:0]          in_position;
  logic signed [pia_pkg::VALUE_W-1:0] out_value;
  logic [pia_pkg::FILL_W-1:0]         out_fill;

  // Unpack the input item.
  assign in_value    = $signed(s_axis_tdata_i[pia_pkg::VALUE_W-1:0]);
  assign in_position = s_axis_tdata_i[pia_pkg::VALUE_W +: pia_pkg::POS_W];

  pia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .req_type_i (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pia_dp #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .in_value_i    (in_value),
    .in_position_i (in_position),
    .out_tready_i  (m_axis_tready_i),
    .stat_o        (stat),
    .out_tvalid_o  (m_axis_tvalid_o),
    .out_status_o  (m_axis_tuser_o),
    .out_value_o   (out_value),
    .out_last_o    (m_axis_tlast_o),
    .out_fill_o    (out_fill)
  );

  // Pack the result item.
  assign m_axis_tdata_o = {1'b0, out_fill, out_value};

endmodule
